>>> hdl/ctt_pkg.sv
// Package for the configuration text tokenizer.
// Character classes, automaton states, token kinds and lookup functions.
// No dependencies.
`default_nettype none
package ctt_pkg;

	typedef logic [4:0] cls_t;
	typedef logic [4:0] st_t;
	typedef logic [4:0] kind_t;

	localparam cls_t C_NUL = 5'd0, C_WS = 5'd1, C_LF = 5'd2, C_CR = 5'd3, C_QUOTE = 5'd4,
		C_HASH = 5'd5, C_LPAR = 5'd6, C_RPAR = 5'd7, C_STAR = 5'd8, C_PLUS = 5'd9,
		C_COMMA = 5'd10, C_MINUS = 5'd11, C_DOT = 5'd12, C_SLASH = 5'd13, C_DIGIT = 5'd14,
		C_COLON = 5'd15, C_SEMI = 5'd16, C_EQ = 5'd17, C_LSQ = 5'd18, C_BSL = 5'd19,
		C_RSQ = 5'd20, C_UNDER = 5'd21, C_E = 5'd22, C_LETTER = 5'd23, C_LBRACE = 5'd24,
		C_RBRACE = 5'd25, C_INVAL = 5'd26, C_ILL = 5'd27;

	localparam st_t S_START = 5'd0, S_WS = 5'd1, S_LF = 5'd2, S_CR = 5'd3, S_UNCLIT = 5'd4,
		S_LIT = 5'd5, S_HASH = 5'd6, S_HASH2 = 5'd7, S_LPAR = 5'd8, S_RPAR = 5'd9,
		S_PLUS = 5'd10, S_COMMA = 5'd11, S_MINUS = 5'd12, S_SLASH = 5'd13, S_LCOM = 5'd14,
		S_MCOM = 5'd15, S_INT = 5'd16, S_UFLT = 5'd17, S_FLT = 5'd18, S_FEXP = 5'd19,
		S_COLON = 5'd20, S_SEMI = 5'd21, S_EQ = 5'd22, S_LSQ = 5'd23, S_BSL = 5'd24,
		S_RSQ = 5'd25, S_ID = 5'd26, S_LBRACE = 5'd27, S_RBRACE = 5'd28, S_END = 5'd29,
		S_INV = 5'd30, S_NONE = 5'd31;

	localparam kind_t K_ILLEGAL = 5'd0, K_INVALID = 5'd1, K_END = 5'd2, K_ID = 5'd3,
		K_DEFINE = 5'd4, K_CLASS = 5'd5, K_INT = 5'd6, K_FLOAT = 5'd7, K_LIT = 5'd8,
		K_WS = 5'd9, K_LF = 5'd10, K_CR = 5'd11, K_HASH = 5'd12, K_HASH2 = 5'd13,
		K_LPAR = 5'd14, K_RPAR = 5'd15, K_COMMA = 5'd16, K_COLON = 5'd17, K_SEMI = 5'd18,
		K_EQ = 5'd19, K_LSQ = 5'd20, K_BSL = 5'd21, K_RSQ = 5'd22, K_LBRACE = 5'd23,
		K_RBRACE = 5'd24, K_LCOM = 5'd25, K_MCOM = 5'd26, K_NONE = 5'd31;

	localparam logic [1:0] CM_OFF = 2'd0, CM_LINE = 2'd1, CM_BLOCK = 2'd2;
	localparam logic [1:0] KW_BOTH = 2'b11;

	typedef struct packed {
		st_t         ast;
		kind_t       acc;
		logic [31:0] bp;
		logic [31:0] tb;
		logic [31:0] line;
		logic [1:0]  cmode;
		logic        star;
		logic [1:0]  kw;
	} scan_t;

	typedef struct packed {
		logic        emit;
		kind_t       kind;
		logic [31:0] start;
		logic [15:0] len;
		logic [31:0] line;
	} res_t;

	function automatic cls_t classify(input logic [7:0] b);
		cls_t c;
		case (b) inside
			8'd0: c = C_NUL;
			8'd9, 8'd32: c = C_WS;
			8'd10: c = C_LF;
			8'd13: c = C_CR;
			8'd34: c = C_QUOTE;
			8'd35: c = C_HASH;
			8'd40: c = C_LPAR;
			8'd41: c = C_RPAR;
			8'd42: c = C_STAR;
			8'd43: c = C_PLUS;
			8'd44: c = C_COMMA;
			8'd45: c = C_MINUS;
			8'd46: c = C_DOT;
			8'd47: c = C_SLASH;
			8'd58: c = C_COLON;
			8'd59: c = C_SEMI;
			8'd61: c = C_EQ;
			8'd91: c = C_LSQ;
			8'd92: c = C_BSL;
			8'd93: c = C_RSQ;
			8'd95: c = C_UNDER;
			8'd101: c = C_E;
			8'd123: c = C_LBRACE;
			8'd125: c = C_RBRACE;
			8'd33, 8'd36, 8'd39, 8'd63: c = C_INVAL;
			[8'd48:8'd57]: c = C_DIGIT;
			[8'd65:8'd90], [8'd97:8'd122]: c = C_LETTER;
			default: c = C_ILL;
		endcase
		return c;
	endfunction

	function automatic st_t step_state(input st_t s, input cls_t c);
		st_t n;
		n = S_NONE;
		case (s)
			S_START: begin
				case (c)
					C_INVAL, C_DOT: n = S_INV;
					C_NUL: n = S_END;
					C_WS: n = S_WS;
					C_LF: n = S_LF;
					C_CR: n = S_CR;
					C_QUOTE: n = S_UNCLIT;
					C_HASH: n = S_HASH;
					C_LPAR: n = S_LPAR;
					C_RPAR: n = S_RPAR;
					C_PLUS: n = S_PLUS;
					C_COMMA: n = S_COMMA;
					C_MINUS: n = S_MINUS;
					C_SLASH: n = S_SLASH;
					C_DIGIT: n = S_INT;
					C_COLON: n = S_COLON;
					C_SEMI: n = S_SEMI;
					C_EQ: n = S_EQ;
					C_LSQ: n = S_LSQ;
					C_BSL: n = S_BSL;
					C_RSQ: n = S_RSQ;
					C_UNDER, C_E, C_LETTER: n = S_ID;
					C_LBRACE: n = S_LBRACE;
					C_RBRACE: n = S_RBRACE;
					default: n = S_NONE;
				endcase
			end
			S_WS: n = (c == C_WS) ? S_WS : S_NONE;
			S_UNCLIT: begin
				if (c == C_QUOTE) n = S_LIT;
				else if (c inside {C_INVAL, C_WS, C_HASH, C_STAR, C_PLUS, C_COMMA, C_MINUS,
					C_DOT, C_SLASH, C_DIGIT, C_COLON, C_BSL, C_UNDER, C_E, C_LETTER,
					C_LBRACE, C_RBRACE}) n = S_UNCLIT;
			end
			S_HASH: n = (c == C_HASH) ? S_HASH2 : S_NONE;
			S_PLUS: n = (c == C_DIGIT) ? S_INT : S_NONE;
			S_MINUS: begin
				if (c == C_WS) n = S_MINUS;
				else if (c == C_DIGIT) n = S_INT;
			end
			S_SLASH: begin
				if (c == C_STAR) n = S_MCOM;
				else if (c == C_SLASH) n = S_LCOM;
			end
			S_INT: begin
				case (c)
					C_DOT: n = S_UFLT;
					C_DIGIT: n = S_INT;
					C_E: n = S_FEXP;
					C_LETTER: n = S_ID;
					default: n = S_NONE;
				endcase
			end
			S_UFLT: n = (c == C_DIGIT) ? S_FLT : S_NONE;
			S_FLT: begin
				if (c == C_DIGIT) n = S_FLT;
				else if (c == C_E) n = S_FEXP;
			end
			S_FEXP: n = (c inside {C_PLUS, C_MINUS, C_DIGIT}) ? S_FEXP : S_NONE;
			S_ID: begin
				if (c inside {C_DIGIT, C_UNDER, C_E, C_LETTER}) n = S_ID;
				else if (c inside {C_INVAL, C_BSL}) n = S_INV;
			end
			default: n = S_NONE;
		endcase
		return n;
	endfunction

	function automatic kind_t kind_of(input st_t s);
		kind_t k;
		case (s)
			S_WS: k = K_WS;
			S_LF: k = K_LF;
			S_CR: k = K_CR;
			S_LIT: k = K_LIT;
			S_HASH: k = K_HASH;
			S_HASH2: k = K_HASH2;
			S_LPAR: k = K_LPAR;
			S_RPAR: k = K_RPAR;
			S_COMMA: k = K_COMMA;
			S_LCOM: k = K_LCOM;
			S_MCOM: k = K_MCOM;
			S_INT: k = K_INT;
			S_FLT, S_FEXP: k = K_FLOAT;
			S_COLON: k = K_COLON;
			S_SEMI: k = K_SEMI;
			S_EQ: k = K_EQ;
			S_LSQ: k = K_LSQ;
			S_BSL: k = K_BSL;
			S_RSQ: k = K_RSQ;
			S_ID: k = K_ID;
			S_LBRACE: k = K_LBRACE;
			S_RBRACE: k = K_RBRACE;
			S_END: k = K_END;
			S_MINUS, S_INV: k = K_INVALID;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] define_char(input logic [2:0] i);
		logic [7:0] ch;
		case (i)
			3'd0: ch = 8'h64;
			3'd1: ch = 8'h65;
			3'd2: ch = 8'h66;
			3'd3: ch = 8'h69;
			3'd4: ch = 8'h6e;
			3'd5: ch = 8'h65;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] class_char(input logic [2:0] i);
		logic [7:0] ch;
		case (i)
			3'd0: ch = 8'h63;
			3'd1: ch = 8'h6c;
			3'd2: ch = 8'h61;
			3'd3, 3'd4: ch = 8'h73;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [15:0] sat16(input logic [31:0] v);
		return (v > 32'd65535) ? 16'hffff : v[15:0];
	endfunction

endpackage
`default_nettype wire

>>> hdl/ctt_step.sv
// One scanner step: consumes one byte from the work queue against the scan state.
// Uses ctt_pkg for classes, automaton table and kinds.
`default_nettype none
module ctt_step #(
	parameter int LOOKAHEAD_DEPTH = 2
) (
	input  wire logic [7:0]                         byte_in,
	input  wire logic                               drop_ws,
	input  wire ctt_pkg::scan_t                     cur,
	input  wire logic [$clog2(LOOKAHEAD_DEPTH+1)-1:0] hc,
	output ctt_pkg::scan_t                          nxt,
	output logic [$clog2(LOOKAHEAD_DEPTH+1)-1:0]    hc_n,
	output logic                                    held_wr,
	output logic                                    rep,
	output logic [$clog2(LOOKAHEAD_DEPTH+1)-1:0]    rep_hk,
	output ctt_pkg::res_t                           res
);
	localparam int HCW = $clog2(LOOKAHEAD_DEPTH + 1);

	logic          go;
	logic [31:0]   tb;
	logic [31:0]   idx;
	logic [31:0]   len;
	ctt_pkg::cls_t  c;
	ctt_pkg::st_t   nx;
	ctt_pkg::kind_t k;

	always_comb begin
		nxt = cur;
		hc_n = hc;
		held_wr = 1'b0;
		rep = 1'b0;
		rep_hk = '0;
		res = '0;
		res.line = cur.line;
		go = 1'b1;
		tb = cur.tb;
		idx = '0;
		len = '0;
		c = ctt_pkg::classify(byte_in);
		nx = ctt_pkg::S_NONE;
		k = ctt_pkg::K_NONE;
		if (cur.cmode != ctt_pkg::CM_OFF) begin
			if (byte_in != 8'd0) begin
				go = 1'b0;
				nxt.bp = cur.bp + 32'd1;
				if (byte_in == 8'd10) nxt.line = cur.line + 32'd1;
				if (cur.cmode == ctt_pkg::CM_LINE) begin
					if (byte_in == 8'd10) nxt.cmode = ctt_pkg::CM_OFF;
				end else begin
					if (cur.star && byte_in == 8'h2f) nxt.cmode = ctt_pkg::CM_OFF;
					nxt.star = (byte_in == 8'h2a);
				end
			end else begin
				nxt.cmode = ctt_pkg::CM_OFF;
				nxt.star = 1'b0;
			end
		end
		if (go) begin
			if (cur.ast == ctt_pkg::S_START) tb = cur.bp;
			nxt.tb = tb;
			nx = ctt_pkg::step_state(cur.ast, c);
			if (nx != ctt_pkg::S_NONE) begin
				idx = cur.bp - tb;
				if (idx >= 32'd6 || byte_in != ctt_pkg::define_char(idx[2:0])) nxt.kw[0] = 1'b0;
				if (idx >= 32'd5 || byte_in != ctt_pkg::class_char(idx[2:0])) nxt.kw[1] = 1'b0;
				k = ctt_pkg::kind_of(nx);
				if (k != ctt_pkg::K_NONE) begin
					nxt.acc = k;
					hc_n = '0;
				end else if (cur.ast != ctt_pkg::S_START && nx != ctt_pkg::S_UNCLIT &&
					32'(hc) < LOOKAHEAD_DEPTH) begin
					held_wr = 1'b1;
					hc_n = hc + HCW'(1);
				end
				nxt.ast = nx;
				nxt.bp = cur.bp + 32'd1;
				if (nx == ctt_pkg::S_END) begin
					res.emit = 1'b1;
					res.kind = ctt_pkg::K_END;
					res.start = tb;
					res.len = 16'd1;
				end
			end else if (cur.ast == ctt_pkg::S_START) begin
				res.emit = 1'b1;
				res.kind = ctt_pkg::K_ILLEGAL;
				res.start = cur.bp;
				res.len = 16'd1;
				nxt.bp = cur.bp + 32'd1;
			end else if (cur.ast == ctt_pkg::S_UNCLIT) begin
				res.emit = 1'b1;
				res.kind = ctt_pkg::K_ILLEGAL;
				res.start = tb;
				res.len = ctt_pkg::sat16(cur.bp - tb);
				rep = 1'b1;
			end else if (cur.acc == ctt_pkg::K_NONE) begin
				res.emit = 1'b1;
				res.kind = ctt_pkg::K_ILLEGAL;
				res.start = tb;
				res.len = 16'd1;
				nxt.bp = tb + 32'd1;
				rep = 1'b1;
				rep_hk = hc;
			end else begin
				len = cur.bp - tb - 32'(hc);
				nxt.bp = tb + len;
				rep = 1'b1;
				rep_hk = hc;
				res.start = tb;
				res.len = ctt_pkg::sat16(len);
				res.kind = cur.acc;
				case (cur.acc)
					ctt_pkg::K_LCOM: nxt.cmode = ctt_pkg::CM_LINE;
					ctt_pkg::K_MCOM: begin
						nxt.cmode = ctt_pkg::CM_BLOCK;
						nxt.star = 1'b0;
					end
					ctt_pkg::K_LF: begin
						nxt.line = cur.line + 32'd1;
						res.emit = !drop_ws;
					end
					ctt_pkg::K_WS, ctt_pkg::K_CR: res.emit = !drop_ws;
					ctt_pkg::K_ID: begin
						res.emit = 1'b1;
						if (len == 32'd6 && cur.kw[0]) res.kind = ctt_pkg::K_DEFINE;
						else if (len == 32'd5 && cur.kw[1]) res.kind = ctt_pkg::K_CLASS;
					end
					default: res.emit = 1'b1;
				endcase
			end
			if (nx == ctt_pkg::S_END || nx == ctt_pkg::S_NONE) begin
				nxt.ast = ctt_pkg::S_START;
				nxt.acc = ctt_pkg::K_NONE;
				hc_n = '0;
				held_wr = 1'b0;
				nxt.kw = ctt_pkg::KW_BOTH;
				nxt.tb = nxt.bp;
			end
			res.line = nxt.line;
		end
	end
endmodule
`default_nettype wire

>>> hdl/config_text_tokenizer.sv
// Top level of the configuration text tokenizer: handshakes, work queue,
// held bytes, result buffer and the sequencer around ctt_step. Uses ctt_pkg.
//
// Each accepted byte is written to the work queue in the idle phase, then is scanned
// one queue entry per clock through a single step unit: the byte itself, plus up to
// LOOKAHEAD_DEPTH+1 replayed bytes (held bytes and the head) when a token closes;
// then the results (0 to 3) go out one per out_valid/out_ready handshake.
// in_ready is high only when the scanner is idle. Up to three tokens per byte;
// last_of_run marks the final one.
`default_nettype none
module config_text_tokenizer #(
	parameter int LOOKAHEAD_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        drop_whitespace_wr,
	input  wire logic        drop_whitespace,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       token_kind,
	output logic [31:0]      token_start,
	output logic [15:0]      token_length,
	output logic [31:0]      line_number,
	output logic             last_of_run
);
	localparam int QCAP = LOOKAHEAD_DEPTH + 2;
	localparam int QIW  = $clog2(QCAP);
	localparam int QNW  = $clog2(QCAP + 1);
	localparam int HCW  = $clog2(LOOKAHEAD_DEPTH + 1);
	localparam int HIW  = (LOOKAHEAD_DEPTH > 1) ? $clog2(LOOKAHEAD_DEPTH) : 1;
	localparam int MAXRES = 3;

	localparam logic [1:0] PH_IDLE = 2'd0, PH_RUN = 2'd1, PH_OUT = 2'd2;

	logic [1:0]        phase_q;
	logic              drop_q;
	ctt_pkg::scan_t    scan_q, scan_d;
	logic [HCW-1:0]    hc_q, hc_d;
	logic [7:0]        held_q [LOOKAHEAD_DEPTH];
	logic [7:0]        queue_q [QCAP];
	logic [7:0]        queue_d [QCAP];
	logic [QNW-1:0]    qn_q, qn_d;
	ctt_pkg::res_t     rbuf_q [MAXRES];
	logic [1:0]        rn_q, rd_q;
	logic              held_wr, rep;
	logic [HCW-1:0]    rep_hk;
	ctt_pkg::res_t     res;
	int                kk;

	ctt_step #(.LOOKAHEAD_DEPTH(LOOKAHEAD_DEPTH)) u_step (
		.byte_in (queue_q[0]),
		.drop_ws (drop_q),
		.cur     (scan_q),
		.hc      (hc_q),
		.nxt     (scan_d),
		.hc_n    (hc_d),
		.held_wr (held_wr),
		.rep     (rep),
		.rep_hk  (rep_hk),
		.res     (res)
	);

	// pop the head, then push held bytes and the head back in front on replay
	always_comb begin
		kk = 32'(rep_hk) + 1;
		for (int i = 0; i < QCAP; i++) queue_d[i] = queue_q[i];
		qn_d = qn_q - QNW'(1);
		if (rep && (32'(qn_q) - 1 + kk) <= QCAP) begin
			for (int i = 0; i < QCAP; i++) begin
				if (i >= kk) queue_d[i] = queue_q[QIW'(i + 1 - kk)];
			end
			for (int j = 0; j < LOOKAHEAD_DEPTH; j++) begin
				if (j < 32'(rep_hk)) queue_d[j] = held_q[j];
			end
			queue_d[QIW'(rep_hk)] = queue_q[0];
			qn_d = QNW'(32'(qn_q) - 1 + kk);
		end else begin
			for (int i = 0; i < QCAP - 1; i++) queue_d[i] = queue_q[i + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			drop_q <= 1'b1;
			scan_q <= '{ast: ctt_pkg::S_START, acc: ctt_pkg::K_NONE, bp: 32'd0, tb: 32'd0,
				line: 32'd1, cmode: ctt_pkg::CM_OFF, star: 1'b0, kw: ctt_pkg::KW_BOTH};
			hc_q <= '0;
			qn_q <= '0;
			rn_q <= '0;
			rd_q <= '0;
		end else begin
			if (drop_whitespace_wr) drop_q <= drop_whitespace;
			case (phase_q)
				PH_IDLE: begin
					if (in_valid) begin
						queue_q[0] <= in_byte;
						qn_q <= QNW'(1);
						rn_q <= '0;
						rd_q <= '0;
						phase_q <= PH_RUN;
					end
				end
				PH_RUN: begin
					scan_q <= scan_d;
					hc_q <= hc_d;
					if (held_wr) held_q[HIW'(hc_q)] <= queue_q[0];
					for (int i = 0; i < QCAP; i++) queue_q[i] <= queue_d[i];
					qn_q <= qn_d;
					if (res.emit && rn_q < 2'(MAXRES)) begin
						rbuf_q[rn_q] <= res;
						rn_q <= rn_q + 2'd1;
					end
					if (qn_d == '0) begin
						if (rn_q != '0 || res.emit) phase_q <= PH_OUT;
						else phase_q <= PH_IDLE;
					end
				end
				PH_OUT: begin
					if (out_ready) begin
						rd_q <= rd_q + 2'd1;
						if (rd_q == rn_q - 2'd1) phase_q <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	assign in_ready     = (phase_q == PH_IDLE);
	assign out_valid    = (phase_q == PH_OUT);
	assign token_kind   = rbuf_q[rd_q].kind;
	assign token_start  = rbuf_q[rd_q].start;
	assign token_length = rbuf_q[rd_q].len;
	assign line_number  = rbuf_q[rd_q].line;
	assign last_of_run  = (rd_q == rn_q - 2'd1);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(qn_q) <= QCAP) else $error("work queue overflow");
	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_RUN |-> qn_q != '0) else $error("scanning with empty queue");
	a_out_has_res: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_OUT |-> (rn_q != '0 && rd_q < rn_q)) else $error("bad result read");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> phase_q == PH_RUN && qn_q == QNW'(1))
		else $error("accepted byte not queued");
endmodule
`default_nettype wire
